[src/signed_sum_residue_reachability_assert.svh]
// Assertion macros for the signed sum residue reachability block.
// Included by the top level; no other dependencies.
`ifndef SIGNED_SUM_RESIDUE_REACHABILITY_ASSERT_SVH
`define SIGNED_SUM_RESIDUE_REACHABILITY_ASSERT_SVH

`ifndef ASSERT_OFF
`define SGSR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sgsr assertion failed");
`define SGSR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sgsr forbidden condition seen");
`else
`define SGSR_ASSERT(lbl, clk, rstn, prop)
`define SGSR_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[src/sgsr_pkg.sv]
// Shared constants for the signed sum residue reachability block.
// No dependencies; used by every module of the block.
`default_nettype none

package sgsr_pkg;

  localparam int MAX_MOD_DEF    = 128;
  localparam int VALUE_BITS_DEF = 16;
  localparam int MOD_W          = 8;
  localparam int QUEUE_DEPTH    = 2;

endpackage

`default_nettype wire

[src/signed_sum_residue_reachability.sv]
// Top level of the signed sum residue reachability block: modulus register,
// front end, residue queue and back end. Depends on sgsr_pkg and the assert header.
// Each word carries one signed term; the block tracks which residues mod k a sum
// of the terms, each added or subtracted, can reach, and on a word marked last it
// returns one result word telling whether residue 0 is reachable, then restarts.
// The front end takes a new word only once the previous term has gone into the
// queue: the residue of each term is formed one bit per cycle by a shift and
// conditional subtract unit. The back end registers the updated residue set as it
// takes each residue, and a two entry queue lets the front work on the next term
// while the back end waits on a stalled result. A write of the modulus restarts
// the sequence; a modulus of 0 acts as 1 and one above MAX_MOD acts as MAX_MOD.
`default_nettype none
`include "signed_sum_residue_reachability_assert.svh"

module signed_sum_residue_reachability #(
  parameter int MAX_MOD    = sgsr_pkg::MAX_MOD_DEF,
  parameter int VALUE_BITS = sgsr_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sgsr_pkg::MOD_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] term_value_i,
  input  logic                         last_term_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         divisible_o
);

  localparam int KW = $clog2(MAX_MOD + 1);
  localparam int RW = $clog2(MAX_MOD);
  localparam int CW = (KW > sgsr_pkg::MOD_W) ? KW : sgsr_pkg::MOD_W;

  logic [sgsr_pkg::MOD_W-1:0] modulus_q;
  logic [KW-1:0]              k_eff;
  logic [MAX_MOD-1:0]         kmask;

  logic                       push_valid;
  logic                       push_ready;
  logic [RW-1:0]              push_residue;
  logic                       push_last;
  logic                       pop_valid;
  logic                       pop_ready;
  logic [RW:0]                pop_data;
  logic [MAX_MOD-1:0]         reach;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= sgsr_pkg::MOD_W'(1);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (modulus_q == '0) begin
      k_eff = KW'(1);
    end else if (CW'(modulus_q) > CW'(MAX_MOD)) begin
      k_eff = KW'(MAX_MOD);
    end else begin
      k_eff = KW'(modulus_q);
    end
    kmask = ~({MAX_MOD{1'b1}} << k_eff);
  end

  sgsr_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_MOD   (MAX_MOD)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .term_value_i  (term_value_i),
    .last_term_i   (last_term_i),
    .k_i           (k_eff),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_residue_o(push_residue),
    .push_last_o   (push_last)
  );

  sgsr_queue #(
    .DATA_W(RW + 1),
    .DEPTH (sgsr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_last, push_residue}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  sgsr_back #(
    .MAX_MOD(MAX_MOD)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_residue_i(pop_data[RW-1:0]),
    .pop_last_i   (pop_data[RW]),
    .k_i          (k_eff),
    .clear_i      (cfg_we_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .divisible_o  (divisible_o),
    .reach_o      (reach)
  );

  // A modulus write always restarts the sequence with only residue 0 reachable.
  `SGSR_ASSERT(a_cfg_clears_set, clk_i, rst_ni, cfg_we_i |=> (reach == MAX_MOD'(1)))

  // The residue set never holds a residue at or above the current modulus.
  `SGSR_ASSERT_NEVER(a_set_in_range, clk_i, rst_ni, ((reach & ~kmask) != '0))

  // Every residue handed to the queue is already reduced below k.
  `SGSR_ASSERT(a_residue_reduced, clk_i, rst_ni, push_valid |-> (KW'(push_residue) < k_eff))

endmodule

`default_nettype wire

[src/sgsr_front.sv]
// Front end: accepts words and reduces each value modulo k, one bit per cycle.
// Depends on sgsr_pkg for default parameter values.
`default_nettype none

module sgsr_front #(
  parameter int VALUE_BITS = sgsr_pkg::VALUE_BITS_DEF,
  parameter int MAX_MOD    = sgsr_pkg::MAX_MOD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_BITS-1:0]  term_value_i,
  input  logic                          last_term_i,
  input  logic [$clog2(MAX_MOD+1)-1:0]  k_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [$clog2(MAX_MOD)-1:0]    push_residue_o,
  output logic                          push_last_o
);

  localparam int KW  = $clog2(MAX_MOD + 1);
  localparam int RW  = $clog2(MAX_MOD);
  localparam int RW1 = RW + 1;
  localparam int CW  = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_PUSH} state_e;

  state_e                state_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic                  neg_q;
  logic                  last_q;
  logic [RW-1:0]         rem_q;
  logic [CW-1:0]         cnt_q;

  logic [RW1-1:0]        step_w;
  logic [RW1-1:0]        step_red;
  logic [RW-1:0]         rem_d;
  logic [VALUE_BITS-1:0] mag_in;

  always_comb begin
    step_w   = {rem_q, mag_q[VALUE_BITS-1]};
    step_red = (step_w >= RW1'(k_i)) ? (step_w - RW1'(k_i)) : step_w;
    rem_d    = RW'(step_red);
    mag_in   = term_value_i[VALUE_BITS-1] ? VALUE_BITS'(-term_value_i)
                                          : VALUE_BITS'(term_value_i);
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign push_valid_o   = (state_q == ST_PUSH);
  assign push_last_o    = last_q;
  assign push_residue_o = (neg_q && (rem_q != '0)) ? RW'(k_i - KW'(rem_q)) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            cnt_q   <= CW'(VALUE_BITS);
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      mag_q  <= mag_in;
      neg_q  <= term_value_i[VALUE_BITS-1];
      last_q <= last_term_i;
      rem_q  <= '0;
    end else if (state_q == ST_RUN) begin
      mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

[src/sgsr_queue.sv]
// Short FIFO that carries reduced residues from the front end to the back end.
// Depends on sgsr_pkg for the default depth.
`default_nettype none

module sgsr_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = sgsr_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q;
  logic [PW-1:0]     rd_ptr_q;
  logic [NW-1:0]     count_q;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (count_q != NW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[src/sgsr_back.sv]
// Back end: holds the reachable residue set, rotates it by plus and minus r,
// and drives the result register. Depends on sgsr_pkg for defaults.
`default_nettype none

module sgsr_back #(
  parameter int MAX_MOD = sgsr_pkg::MAX_MOD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  logic [$clog2(MAX_MOD)-1:0]    pop_residue_i,
  input  logic                          pop_last_i,
  input  logic [$clog2(MAX_MOD+1)-1:0]  k_i,
  input  logic                          clear_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          divisible_o,
  output logic [MAX_MOD-1:0]            reach_o
);

  localparam int KW = $clog2(MAX_MOD + 1);
  localparam int SW = 2 * MAX_MOD;

  logic [MAX_MOD-1:0] reach_q;
  logic               out_valid_q;
  logic               divisible_q;

  logic [SW-1:0]      cur_w;
  logic [SW-1:0]      shl_p;
  logic [SW-1:0]      shl_m;
  logic [KW-1:0]      minus_amt;
  logic [MAX_MOD-1:0] kmask;
  logic [MAX_MOD-1:0] next_set;
  logic               advance;

  always_comb begin
    cur_w     = SW'(reach_q);
    minus_amt = k_i - KW'(pop_residue_i);
    shl_p     = cur_w << pop_residue_i;
    shl_m     = cur_w << minus_amt;
    kmask     = ~({MAX_MOD{1'b1}} << k_i);
    next_set  = (MAX_MOD'(shl_p | (shl_p >> k_i)) | MAX_MOD'(shl_m | (shl_m >> k_i)))
                & kmask;
  end

  assign pop_ready_o = !pop_last_i || !out_valid_q || !out_stall_i;
  assign advance     = pop_valid_i && pop_ready_o;
  assign out_valid_o = out_valid_q;
  assign divisible_o = divisible_q;
  assign reach_o     = reach_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q     <= MAX_MOD'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        reach_q <= MAX_MOD'(1);
      end else if (advance) begin
        reach_q <= pop_last_i ? MAX_MOD'(1) : next_set;
      end
      if (advance && pop_last_i) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pop_last_i) begin
      divisible_q <= next_set[0];
    end
  end

endmodule

`default_nettype wire
